// ===== hdl/owbm_pkg.sv =====
// Shared types, register indexes and helpers for the one-wire bus master.
// Used by owbm_step and onewire_bus_master; has no dependencies.
package owbm_pkg;

	localparam int TICK_W   = 10;
	localparam int CFG_IDX_W = 3;
	localparam int BYTE_W   = 8;
	localparam int BIT_IDX_W = 3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_DELAY = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_SHORT     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LONG      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_READ_RECOVERY  = 3'd5;

	// Register values after reset
	localparam logic [TICK_W-1:0] RESET_LOW_DEFAULT      = 10'd500;
	localparam logic [TICK_W-1:0] PRESENCE_DELAY_DEFAULT = 10'd80;
	localparam logic [TICK_W-1:0] RESET_TAIL_DEFAULT     = 10'd400;
	localparam logic [TICK_W-1:0] SLOT_SHORT_DEFAULT     = 10'd2;
	localparam logic [TICK_W-1:0] SLOT_LONG_DEFAULT      = 10'd70;
	localparam logic [TICK_W-1:0] READ_RECOVERY_DEFAULT  = 10'd50;

	typedef enum logic [1:0] {
		CMD_TICK  = 2'd0,
		CMD_RESET = 2'd1,
		CMD_WRITE = 2'd2,
		CMD_READ  = 2'd3
	} cmd_t;

	typedef enum logic [10:0] {
		PH_IDLE       = 11'b000_0000_0001,
		PH_RST_LOW    = 11'b000_0000_0010,
		PH_RST_WAIT   = 11'b000_0000_0100,
		PH_RST_SAMPLE = 11'b000_0000_1000,
		PH_RST_TAIL   = 11'b000_0001_0000,
		PH_WR_LOW     = 11'b000_0010_0000,
		PH_WR_HIGH    = 11'b000_0100_0000,
		PH_RD_LOW     = 11'b000_1000_0000,
		PH_RD_GAP     = 11'b001_0000_0000,
		PH_RD_SAMPLE  = 11'b010_0000_0000,
		PH_RD_REC     = 11'b100_0000_0000
	} phase_t;

	typedef struct packed {
		logic [TICK_W-1:0] reset_low;
		logic [TICK_W-1:0] presence_delay;
		logic [TICK_W-1:0] reset_tail;
		logic [TICK_W-1:0] slot_short;
		logic [TICK_W-1:0] slot_long;
		logic [TICK_W-1:0] read_recovery;
	} cfg_t;

	typedef struct packed {
		phase_t               phase;
		logic [TICK_W-1:0]    timer;
		logic [BIT_IDX_W-1:0] bit_count;
		logic [BYTE_W-1:0]    shift_byte;
		logic                 presence;
		logic [BYTE_W-1:0]    last_read;
	} state_t;

	typedef struct packed {
		logic [1:0]        command;
		logic [BYTE_W-1:0] data_byte;
		logic              line_level;
	} item_t;

	typedef struct packed {
		logic              drive_low;
		logic              busy_res;
		logic              done_res;
		logic [BYTE_W-1:0] read_byte;
		logic              presence;
	} result_t;

	// A programmed duration of zero counts as one tick
	function automatic logic [TICK_W-1:0] at_least_one(input logic [TICK_W-1:0] v);
		return (v == '0) ? TICK_W'(1) : v;
	endfunction

endpackage

// ===== hdl/owbm_in_if.sv =====
// Command channel of the one-wire bus master: valid/ready plus one tick's item.
// No dependencies.
interface owbm_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] command;
	logic [7:0] data_byte;
	logic       line_level;

	modport source (output valid, output command, output data_byte, output line_level,
		input ready);
	modport sink (input valid, input command, input data_byte, input line_level,
		output ready);
endinterface

// ===== hdl/owbm_out_if.sv =====
// Result channel of the one-wire bus master: valid/ready plus one tick's result.
// No dependencies.
interface owbm_out_if;
	logic       valid;
	logic       ready;
	logic       drive_low;
	logic       busy_res;
	logic       done_res;
	logic [7:0] read_byte;
	logic       presence;

	modport source (output valid, output drive_low, output busy_res, output done_res,
		output read_byte, output presence, input ready);
	modport sink (input valid, input drive_low, input busy_res, input done_res,
		input read_byte, input presence, output ready);
endinterface

// ===== hdl/owbm_step.sv =====
// Next-state and result logic for one bus tick of the one-wire master.
// Depends on owbm_pkg.
module owbm_step #(
	parameter int BITS_PER_BYTE = 8
) (
	input  owbm_pkg::state_t  state,
	input  owbm_pkg::cfg_t    cfg,
	input  owbm_pkg::item_t   item,
	output owbm_pkg::state_t  state_next,
	output owbm_pkg::result_t result
);
	import owbm_pkg::*;

	localparam logic [BIT_IDX_W-1:0] LAST_BIT = BIT_IDX_W'(BITS_PER_BYTE - 1);

	state_t            nxt;
	logic              drive;
	logic              done;
	logic              finish;
	logic [TICK_W-1:0] tail;
	logic [BYTE_W-1:0] shifted;

	// Run one tick of the current phase
	always_comb begin
		nxt     = state;
		drive   = 1'b0;
		finish  = 1'b0;
		tail    = '0;
		shifted = state.shift_byte >> 1;
		case (state.phase)
			PH_IDLE: begin
				case (cmd_t'(item.command))
					CMD_RESET: begin
						nxt.phase = PH_RST_LOW;
						nxt.timer = at_least_one(cfg.reset_low);
					end
					CMD_WRITE: begin
						nxt.shift_byte = item.data_byte;
						nxt.bit_count  = '0;
						nxt.phase      = PH_WR_LOW;
						nxt.timer      = at_least_one(item.data_byte[0] ?
							cfg.slot_short : cfg.slot_long);
					end
					CMD_READ: begin
						nxt.shift_byte = '0;
						nxt.bit_count  = '0;
						nxt.phase      = PH_RD_LOW;
					end
					default: ;
				endcase
			end
			PH_RST_LOW: begin
				drive = 1'b1;
				if (state.timer > TICK_W'(1)) begin
					nxt.timer = state.timer - TICK_W'(1);
				end else begin
					nxt.phase = PH_RST_WAIT;
					nxt.timer = at_least_one(cfg.presence_delay);
				end
			end
			PH_RST_WAIT: begin
				if (state.timer > TICK_W'(1)) begin
					nxt.timer = state.timer - TICK_W'(1);
				end else begin
					nxt.phase = PH_RST_SAMPLE;
				end
			end
			PH_RST_SAMPLE: begin
				nxt.presence = ~item.line_level;
				tail = at_least_one(cfg.reset_tail);
				if (tail <= TICK_W'(1)) begin
					finish = 1'b1;
				end else begin
					nxt.phase = PH_RST_TAIL;
					nxt.timer = tail - TICK_W'(1);
				end
			end
			PH_RST_TAIL: begin
				if (state.timer > TICK_W'(1)) begin
					nxt.timer = state.timer - TICK_W'(1);
				end else begin
					finish = 1'b1;
				end
			end
			PH_WR_LOW: begin
				drive = 1'b1;
				if (state.timer > TICK_W'(1)) begin
					nxt.timer = state.timer - TICK_W'(1);
				end else begin
					nxt.phase = PH_WR_HIGH;
					nxt.timer = at_least_one(state.shift_byte[0] ?
						cfg.slot_long : cfg.slot_short);
				end
			end
			PH_WR_HIGH: begin
				if (state.timer > TICK_W'(1)) begin
					nxt.timer = state.timer - TICK_W'(1);
				end else begin
					nxt.shift_byte = shifted;
					if (state.bit_count >= LAST_BIT) begin
						finish = 1'b1;
					end else begin
						nxt.bit_count = state.bit_count + BIT_IDX_W'(1);
						nxt.phase     = PH_WR_LOW;
						nxt.timer     = at_least_one(shifted[0] ?
							cfg.slot_short : cfg.slot_long);
					end
				end
			end
			PH_RD_LOW: begin
				drive     = 1'b1;
				nxt.phase = PH_RD_GAP;
			end
			PH_RD_GAP: begin
				nxt.phase = PH_RD_SAMPLE;
			end
			PH_RD_SAMPLE: begin
				if (item.line_level) begin
					nxt.shift_byte[state.bit_count] = 1'b1;
				end
				tail = at_least_one(cfg.read_recovery);
				if (tail > TICK_W'(1)) begin
					nxt.phase = PH_RD_REC;
					nxt.timer = tail - TICK_W'(1);
				end else begin
					// one-tick recovery ends on the sample tick itself
					nxt.timer = TICK_W'(1);
					if (state.bit_count >= LAST_BIT) begin
						nxt.last_read = nxt.shift_byte;
						finish = 1'b1;
					end else begin
						nxt.bit_count = state.bit_count + BIT_IDX_W'(1);
						nxt.phase     = PH_RD_LOW;
					end
				end
			end
			PH_RD_REC: begin
				if (state.timer > TICK_W'(1)) begin
					nxt.timer = state.timer - TICK_W'(1);
				end else if (state.bit_count >= LAST_BIT) begin
					nxt.last_read = state.shift_byte;
					finish = 1'b1;
				end else begin
					nxt.bit_count = state.bit_count + BIT_IDX_W'(1);
					nxt.phase     = PH_RD_LOW;
				end
			end
			default: begin
				nxt.phase = PH_IDLE;
			end
		endcase
		done = finish;
		if (finish) begin
			nxt.phase = PH_IDLE;
			nxt.timer = '0;
		end
	end

	assign state_next       = nxt;
	assign result.drive_low = drive;
	assign result.busy_res  = (state.phase != PH_IDLE);
	assign result.done_res  = done;
	assign result.read_byte = nxt.last_read;
	assign result.presence  = nxt.presence;

endmodule

// ===== hdl/onewire_bus_master.sv =====
// One-wire bus master timing engine. Every transfer on the request channel is one
// microsecond tick of bus time and yields exactly one result transfer, in order.
// A transfer is taken in every cycle unless results back up: the tick's item is held
// in an input register, one pass of the phase logic updates the bus state and fills
// the result register, and the sustained rate is one tick per clock while results are
// taken, set by the phase/timer update loop. A full result register that is not taken
// stalls the input side; nothing is dropped. Write the timing registers only while no
// operation is running.
// Depends on owbm_pkg, owbm_in_if, owbm_out_if and owbm_step.
module onewire_bus_master #(
	parameter int BITS_PER_BYTE = 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [owbm_pkg::TICK_W-1:0]       cfg_data,
	owbm_in_if.sink                           request,
	owbm_out_if.source                        response
);
	import owbm_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_next;
	item_t   item_s1;
	logic    valid_s1;
	result_t step_result;
	result_t result_q;
	logic    out_valid_q;
	logic    advance;
	item_t   item_in;

	// Timing registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low      <= RESET_LOW_DEFAULT;
			cfg_q.presence_delay <= PRESENCE_DELAY_DEFAULT;
			cfg_q.reset_tail     <= RESET_TAIL_DEFAULT;
			cfg_q.slot_short     <= SLOT_SHORT_DEFAULT;
			cfg_q.slot_long      <= SLOT_LONG_DEFAULT;
			cfg_q.read_recovery  <= READ_RECOVERY_DEFAULT;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_RESET_LOW:      cfg_q.reset_low      <= cfg_data;
				CFG_PRESENCE_DELAY: cfg_q.presence_delay <= cfg_data;
				CFG_RESET_TAIL:     cfg_q.reset_tail     <= cfg_data;
				CFG_SLOT_SHORT:     cfg_q.slot_short     <= cfg_data;
				CFG_SLOT_LONG:      cfg_q.slot_long      <= cfg_data;
				CFG_READ_RECOVERY:  cfg_q.read_recovery  <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the input stage when the result register can take its outcome
	assign advance       = valid_s1 && (!out_valid_q || response.ready);
	assign request.ready = !valid_s1 || advance;

	assign item_in.command    = request.command;
	assign item_in.data_byte  = request.data_byte;
	assign item_in.line_level = request.line_level;

	// Hold the accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (request.ready) begin
			valid_s1 <= request.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (request.valid && request.ready) begin
			item_s1 <= item_in;
		end
	end

	owbm_step #(
		.BITS_PER_BYTE(BITS_PER_BYTE)
	) u_step (
		.state      (state_q),
		.cfg        (cfg_q),
		.item       (item_s1),
		.state_next (state_next),
		.result     (step_result)
	);

	// Commit the bus state once per processed tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase      <= PH_IDLE;
			state_q.timer      <= '0;
			state_q.bit_count  <= '0;
			state_q.shift_byte <= '0;
			state_q.presence   <= 1'b0;
			state_q.last_read  <= '0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// Result register; drop the valid once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (response.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= step_result;
		end
	end

	assign response.valid     = out_valid_q;
	assign response.drive_low = result_q.drive_low;
	assign response.busy_res  = result_q.busy_res;
	assign response.done_res  = result_q.done_res;
	assign response.read_byte = result_q.read_byte;
	assign response.presence  = result_q.presence;

endmodule

// ===== bench/onewire_bus_master_tb.sv =====
// Self-checking bench for onewire_bus_master: drives bus ticks and checks every result
// against a tick-level predictor of the reset, write-byte and read-byte timing.
// Depends on owbm_pkg, owbm_in_if, owbm_out_if and the onewire_bus_master RTL.
`timescale 1ns / 100ps

module onewire_bus_master_tb;
	import owbm_pkg::*;

	localparam int BYTE_BITS = 8;

	typedef struct packed {
		cmd_t              command;
		logic [BYTE_W-1:0] data_byte;
		logic              line_level;
	} tick_item_t;

	// Level presented on the bus while an operation is run out
	typedef enum {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [TICK_W-1:0]    cfg_data;

	owbm_in_if  request_ch ();
	owbm_out_if result_ch ();

	onewire_bus_master #(
		.BITS_PER_BYTE(BYTE_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.request  (request_ch),
		.response (result_ch)
	);

	always #2 clk = ~clk;

	// Predicted bus state and timing registers
	cfg_t              timing;
	phase_t            bus_phase = PH_IDLE;
	logic [TICK_W-1:0] slot_timer = '0;
	logic [2:0]        bit_idx = '0;
	logic [BYTE_W-1:0] shifter = '0;
	logic              presence_seen = 1'b0;
	logic [BYTE_W-1:0] last_read_byte = '0;

	tick_item_t tick_backlog[$];
	result_t    due_results[$];
	tick_item_t cur_tick;

	int  ticks_queued = 0;
	int  ticks_taken = 0;
	int  mismatches = 0;
	int  settings_used = 1;
	int  resets_started = 0;
	int  writes_started = 0;
	int  reads_started = 0;
	int  gap_left = 0;
	int  stall_left = 0;
	logic idle_on;

	function automatic logic [TICK_W-1:0] ticks_or_one(input logic [TICK_W-1:0] v);
		return (v == '0) ? TICK_W'(1) : v;
	endfunction

	// Low and high parts of a write slot for the bit now at the bottom of the shifter
	function automatic logic [TICK_W-1:0] low_span();
		return ticks_or_one(shifter[0] ? timing.slot_short : timing.slot_long);
	endfunction

	function automatic logic [TICK_W-1:0] high_span();
		return ticks_or_one(shifter[0] ? timing.slot_long : timing.slot_short);
	endfunction

	// Advance the predicted bus by one tick and queue the result it yields
	task automatic run_bus_tick(input tick_item_t it);
		result_t           r;
		logic              finish;
		logic              bit_end;
		logic [TICK_W-1:0] tail;
		r = '0;
		r.busy_res = (bus_phase != PH_IDLE);
		finish = 1'b0;
		bit_end = 1'b0;
		case (bus_phase)
		PH_IDLE: begin
			case (it.command)
			CMD_RESET: begin
				bus_phase = PH_RST_LOW;
				slot_timer = ticks_or_one(timing.reset_low);
				resets_started++;
			end
			CMD_WRITE: begin
				shifter = it.data_byte;
				bit_idx = '0;
				bus_phase = PH_WR_LOW;
				slot_timer = low_span();
				writes_started++;
			end
			CMD_READ: begin
				shifter = '0;
				bit_idx = '0;
				bus_phase = PH_RD_LOW;
				reads_started++;
			end
			default: ;
			endcase
		end
		PH_RST_LOW: begin
			r.drive_low = 1'b1;
			if (slot_timer > 1) begin
				slot_timer--;
			end else begin
				bus_phase = PH_RST_WAIT;
				slot_timer = ticks_or_one(timing.presence_delay);
			end
		end
		PH_RST_WAIT: begin
			if (slot_timer > 1) slot_timer--;
			else bus_phase = PH_RST_SAMPLE;
		end
		PH_RST_SAMPLE: begin
			presence_seen = ~it.line_level;
			tail = ticks_or_one(timing.reset_tail);
			if (tail <= 1) begin
				finish = 1'b1;
			end else begin
				bus_phase = PH_RST_TAIL;
				slot_timer = tail - 1'b1;
			end
		end
		PH_RST_TAIL: begin
			if (slot_timer > 1) slot_timer--;
			else finish = 1'b1;
		end
		PH_WR_LOW: begin
			r.drive_low = 1'b1;
			if (slot_timer > 1) begin
				slot_timer--;
			end else begin
				bus_phase = PH_WR_HIGH;
				slot_timer = high_span();
			end
		end
		PH_WR_HIGH: begin
			if (slot_timer > 1) begin
				slot_timer--;
			end else begin
				shifter = shifter >> 1;
				if (bit_idx >= BYTE_BITS - 1) begin
					finish = 1'b1;
				end else begin
					bit_idx++;
					bus_phase = PH_WR_LOW;
					slot_timer = low_span();
				end
			end
		end
		PH_RD_LOW: begin
			r.drive_low = 1'b1;
			bus_phase = PH_RD_GAP;
		end
		PH_RD_GAP: bus_phase = PH_RD_SAMPLE;
		PH_RD_SAMPLE: begin
			if (it.line_level) shifter[bit_idx] = 1'b1;
			tail = ticks_or_one(timing.read_recovery);
			// A one-tick recovery ends the bit on the sample tick itself
			if (tail > 1) begin
				bus_phase = PH_RD_REC;
				slot_timer = tail - 1'b1;
			end else begin
				bit_end = 1'b1;
			end
		end
		PH_RD_REC: begin
			if (slot_timer > 1) slot_timer--;
			else bit_end = 1'b1;
		end
		default: bus_phase = PH_IDLE;
		endcase

		// Close a read bit: either the byte is complete or the next slot starts
		if (bit_end) begin
			if (bit_idx >= BYTE_BITS - 1) begin
				last_read_byte = shifter;
				finish = 1'b1;
			end else begin
				bit_idx++;
				bus_phase = PH_RD_LOW;
			end
		end
		if (finish) begin
			bus_phase = PH_IDLE;
			slot_timer = '0;
			r.done_res = 1'b1;
		end
		r.read_byte = last_read_byte;
		r.presence = presence_seen;
		due_results.push_back(r);
	endtask

	// Request side: present queued ticks, predict each one on its transfer
	always @(posedge clk) begin : tick_driver
		if (!arst_n) begin
			request_ch.valid <= 1'b0;
		end else begin
			if (request_ch.valid && request_ch.ready) begin
				run_bus_tick(cur_tick);
				ticks_taken++;
			end
			if (!request_ch.valid || request_ch.ready) begin
				if (idle_on && gap_left > 0) begin
					gap_left--;
					request_ch.valid <= 1'b0;
				end else if (tick_backlog.size() > 0) begin
					cur_tick = tick_backlog.pop_front();
					request_ch.valid <= 1'b1;
					request_ch.command <= cur_tick.command;
					request_ch.data_byte <= cur_tick.data_byte;
					request_ch.line_level <= cur_tick.line_level;
					if (idle_on && $urandom_range(0, 11) == 0) gap_left = $urandom_range(1, 17);
				end else begin
					request_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Result side: check each transfer against the oldest prediction, stall at random
	always @(posedge clk) begin : result_monitor
		result_t want;
		if (!arst_n) begin
			result_ch.ready <= 1'b0;
		end else begin
			if (result_ch.valid && result_ch.ready) begin
				if (due_results.size() == 0) begin
					$error("result transfer with nothing predicted");
					mismatches++;
				end else begin
					want = due_results.pop_front();
					if (result_ch.drive_low !== want.drive_low) begin
						$error("drive_low: expected %0d, got %0d", want.drive_low,
							result_ch.drive_low);
						mismatches++;
					end
					if (result_ch.busy_res !== want.busy_res) begin
						$error("busy_res: expected %0d, got %0d", want.busy_res,
							result_ch.busy_res);
						mismatches++;
					end
					if (result_ch.done_res !== want.done_res) begin
						$error("done_res: expected %0d, got %0d", want.done_res,
							result_ch.done_res);
						mismatches++;
					end
					if (result_ch.read_byte !== want.read_byte) begin
						$error("read_byte: expected %02h, got %02h", want.read_byte,
							result_ch.read_byte);
						mismatches++;
					end
					if (result_ch.presence !== want.presence) begin
						$error("presence: expected %0d, got %0d", want.presence,
							result_ch.presence);
						mismatches++;
					end
				end
			end
			if (idle_on && stall_left > 0) begin
				stall_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 11) == 0) stall_left = $urandom_range(1, 17);
			end
		end
	end

	task automatic queue_tick(input cmd_t cmd, input logic [BYTE_W-1:0] data, input logic lvl);
		tick_item_t t;
		t.command = cmd;
		t.data_byte = data;
		t.line_level = lvl;
		tick_backlog.push_back(t);
		ticks_queued++;
	endtask

	// Feed plain ticks until every transfer is checked and the bus is idle again
	task automatic settle_bus(input line_mode_t mode);
		logic lvl;
		do begin
			while (ticks_taken != ticks_queued || due_results.size() != 0) @(posedge clk);
			if (bus_phase != PH_IDLE) begin
				for (int k = 0; k < 16; k++) begin
					case (mode)
					LINE_LOW: lvl = 1'b0;
					LINE_HIGH: lvl = 1'b1;
					default: lvl = 1'($urandom_range(0, 1));
					endcase
					queue_tick(CMD_TICK, BYTE_W'($urandom_range(0, 255)), lvl);
				end
			end
		end while (bus_phase != PH_IDLE);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TICK_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
		CFG_RESET_LOW: timing.reset_low = val;
		CFG_PRESENCE_DELAY: timing.presence_delay = val;
		CFG_RESET_TAIL: timing.reset_tail = val;
		CFG_SLOT_SHORT: timing.slot_short = val;
		CFG_SLOT_LONG: timing.slot_long = val;
		CFG_READ_RECOVERY: timing.read_recovery = val;
		default: ;
		endcase
	endtask

	task automatic program_timing(input cfg_t c);
		write_reg(CFG_RESET_LOW, c.reset_low);
		write_reg(CFG_PRESENCE_DELAY, c.presence_delay);
		write_reg(CFG_RESET_TAIL, c.reset_tail);
		write_reg(CFG_SLOT_SHORT, c.slot_short);
		write_reg(CFG_SLOT_LONG, c.slot_long);
		write_reg(CFG_READ_RECOVERY, c.read_recovery);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	function automatic cfg_t make_timing(input int rl, input int pd, input int rt,
		input int ss, input int sl, input int rr);
		cfg_t c;
		c.reset_low = TICK_W'(rl);
		c.presence_delay = TICK_W'(pd);
		c.reset_tail = TICK_W'(rt);
		c.slot_short = TICK_W'(ss);
		c.slot_long = TICK_W'(sl);
		c.read_recovery = TICK_W'(rr);
		return c;
	endfunction

	function automatic cfg_t random_timing(input int top);
		return make_timing($urandom_range(0, top), $urandom_range(0, top),
			$urandom_range(0, top), $urandom_range(0, top), $urandom_range(0, top),
			$urandom_range(0, top));
	endfunction

	// Mostly plain ticks with commands scattered in, landing both idle and busy
	task automatic random_ticks(input int n);
		cmd_t cmd;
		for (int k = 0; k < n; k++) begin
			cmd = ($urandom_range(0, 9) < 7) ? CMD_TICK : cmd_t'($urandom_range(1, 3));
			queue_tick(cmd, BYTE_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end
		settle_bus(LINE_RANDOM);
	endtask

	initial begin : stimulus
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_RESET_LOW;
		cfg_data = '0;
		idle_on = 1'b1;
		timing = make_timing(int'(RESET_LOW_DEFAULT), int'(PRESENCE_DELAY_DEFAULT),
			int'(RESET_TAIL_DEFAULT), int'(SLOT_SHORT_DEFAULT), int'(SLOT_LONG_DEFAULT),
			int'(READ_RECOVERY_DEFAULT));
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Power-on timing: idle tick, then a read with commands arriving while busy
		queue_tick(CMD_TICK, 8'hFF, 1'b1);
		queue_tick(CMD_READ, 8'h00, 1'b1);
		queue_tick(CMD_WRITE, 8'hFF, 1'b0);
		queue_tick(CMD_RESET, 8'h00, 1'b1);
		queue_tick(CMD_READ, 8'h00, 1'b0);
		settle_bus(LINE_RANDOM);

		// All durations zero, so each phase lasts one tick
		program_timing(make_timing(0, 0, 0, 0, 0, 0));
		queue_tick(CMD_WRITE, 8'h00, 1'b0);
		settle_bus(LINE_RANDOM);
		queue_tick(CMD_WRITE, 8'hFF, 1'b1);
		queue_tick(CMD_READ, 8'hFF, 1'b1);
		settle_bus(LINE_RANDOM);
		queue_tick(CMD_READ, 8'h00, 1'b0);
		settle_bus(LINE_LOW);
		queue_tick(CMD_READ, 8'h00, 1'b1);
		settle_bus(LINE_HIGH);
		queue_tick(CMD_RESET, 8'h00, 1'b0);
		settle_bus(LINE_HIGH);
		queue_tick(CMD_RESET, 8'h00, 1'b1);
		settle_bus(LINE_LOW);

		// Random traffic over short random timings
		for (int p = 0; p < 3; p++) begin
			program_timing(random_timing(6));
			random_ticks(180);
		end
		program_timing(random_timing(30));
		random_ticks(150);

		// Closing stretch with both sides running flat out
		program_timing(random_timing(4));
		idle_on = 1'b0;
		random_ticks(200);

		repeat (8) @(posedge clk);
		if (due_results.size() != 0) begin
			$error("%0d predicted results never arrived", due_results.size());
		end
		$display("Ran %0d bus ticks over %0d timing settings: %0d resets, %0d writes, %0d reads.",
			ticks_taken, settings_used, resets_started, writes_started, reads_started);
		if (mismatches == 0 && due_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatches found", mismatches);
			$display("RESULT: ERROR");
		end
		$finish;
	end

	// Watchdog for a hung handshake
	initial begin : watchdog
		#16_000_000;
		$display("Timed out after %0d of %0d ticks", ticks_taken, ticks_queued);
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
